@@ rtl/aspect_ratio_reducer_assert.svh @@
// Assertion macros used by the aspect ratio reducer top level.
`ifndef ASPECT_RATIO_REDUCER_ASSERT_SVH
`define ASPECT_RATIO_REDUCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ARR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aspect_ratio_reducer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ARR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aspect_ratio_reducer: next-cycle check failed");

`endif

@@ rtl/arr_pkg.sv @@
// Types, constants and the common ratio table of the aspect ratio reducer.
`default_nettype none

package arr_pkg;

	// Width of a canvas side and of a ratio term.
	localparam int SIDE_BITS = 16;

	// Common ratio table.
	localparam int RATIO_COUNT = 11;
	localparam int RATIO_BITS  = 5;
	localparam int IDX_BITS    = $clog2(RATIO_COUNT);

	localparam logic [RATIO_BITS-1:0] RATIO_NUM [RATIO_COUNT] =
		'{5'd16, 5'd9, 5'd4, 5'd3, 5'd3, 5'd2, 5'd1, 5'd21, 5'd5, 5'd16, 5'd10};
	localparam logic [RATIO_BITS-1:0] RATIO_DEN [RATIO_COUNT] =
		'{5'd9, 5'd16, 5'd3, 5'd4, 5'd2, 5'd3, 5'd1, 5'd9, 5'd4, 5'd10, 5'd16};

	// Cross products: term times side, and gap times term.
	localparam int GAP_BITS = SIDE_BITS + RATIO_BITS;
	localparam int CMP_BITS = GAP_BITS + RATIO_BITS;

	// Snap limit after reset.
	localparam logic [SIDE_BITS-1:0] SNAP_LIMIT_RESET = 16'd64;

	typedef struct packed {
		logic [SIDE_BITS-1:0] width;
		logic [SIDE_BITS-1:0] height;
	} arr_in_t;

	typedef struct packed {
		logic [SIDE_BITS-1:0] ratio_num;
		logic [SIDE_BITS-1:0] ratio_den;
		logic                 snapped;
	} arr_out_t;

	// Status of the shared divider.
	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [SIDE_BITS-1:0] quot;
		logic [SIDE_BITS-1:0] rem;
	} div_rsp_t;

	// Status of the nearest ratio scan.
	typedef struct packed {
		logic                busy;
		logic                done;
		logic [IDX_BITS-1:0] best;
	} scan_rsp_t;

endpackage

`default_nettype wire

@@ rtl/arr_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module arr_divider
	import arr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [SIDE_BITS-1:0] dividend,
	input  wire logic [SIDE_BITS-1:0] divisor,
	output div_rsp_t                  rsp
);

	localparam int CNT_BITS = $clog2(SIDE_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SIDE_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [SIDE_BITS-1:0] rem_q;
	logic [SIDE_BITS-1:0] quo_q;
	logic [SIDE_BITS-1:0] div_q;

	logic [SIDE_BITS:0] shifted;
	logic [SIDE_BITS:0] diff;
	logic               fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign shifted = {rem_q, quo_q[SIDE_BITS-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = (shifted >= {1'b0, div_q});

	// Control: count the quotient bits and pulse done after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= fits ? diff[SIDE_BITS-1:0] : shifted[SIDE_BITS-1:0];
			quo_q <= {quo_q[SIDE_BITS-2:0], fits};
		end else if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/arr_snap_scan.sv @@
// Scan of the common ratio table for the entry nearest to width/height.
`default_nettype none

module arr_snap_scan
	import arr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [SIDE_BITS-1:0] width,
	input  wire logic [SIDE_BITS-1:0] height,
	output scan_rsp_t                 rsp
);

	localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(RATIO_COUNT - 1);

	logic                busy_q;
	logic                done_q;
	logic                cmp_phase_q;
	logic [IDX_BITS-1:0] idx_q;
	logic [IDX_BITS-1:0] best_q;
	logic [GAP_BITS-1:0] gap_q;
	logic [GAP_BITS-1:0] best_gap_q;

	logic [GAP_BITS-1:0] prod_a;
	logic [GAP_BITS-1:0] prod_b;
	logic [CMP_BITS-1:0] lhs;
	logic [CMP_BITS-1:0] rhs;
	logic                nearer;

	// Gap phase: |num*height - den*width| for the current entry.
	assign prod_a = GAP_BITS'(RATIO_NUM[idx_q]) * GAP_BITS'(height);
	assign prod_b = GAP_BITS'(RATIO_DEN[idx_q]) * GAP_BITS'(width);

	// Compare phase: the entry is nearer when gap*den_best < best_gap*den.
	assign lhs    = CMP_BITS'(gap_q) * CMP_BITS'(RATIO_DEN[best_q]);
	assign rhs    = CMP_BITS'(best_gap_q) * CMP_BITS'(RATIO_DEN[idx_q]);
	assign nearer = (idx_q == '0) || (lhs < rhs);

	// Control: a gap phase and then a compare phase for each table entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			cmp_phase_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cmp_phase_q <= !cmp_phase_q;
				if (cmp_phase_q) begin
					if (idx_q == IDX_LAST) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end else if (start) begin
				busy_q      <= 1'b1;
				cmp_phase_q <= 1'b0;
				idx_q       <= '0;
			end
		end
	end

	// Datapath: current gap and the best entry so far.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (!cmp_phase_q) begin
				gap_q <= (prod_a >= prod_b) ? (prod_a - prod_b) : (prod_b - prod_a);
			end else if (nearer) begin
				best_q     <= idx_q;
				best_gap_q <= gap_q;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.best = best_q;

endmodule

`default_nettype wire

@@ rtl/aspect_ratio_reducer.sv @@
// Top level of the aspect ratio reducer: sequencer, registers and output beat.
`default_nettype none
`include "aspect_ratio_reducer_assert.svh"

// Reduces width x height (a zero side counts as one) to lowest terms with
// Euclid's algorithm; when a reduced term exceeds snap_limit the result is
// the nearest entry of an eleven-entry table of common ratios instead, with
// snapped set. One item is in work at a time: in_ready is high only while
// the sequencer is idle, and a finished result waits in the output register
// while the next item is accepted. All remainders and quotients come from
// one shared restoring divider: first the remainder steps of Euclid (1 to
// 23 for 16-bit sides), then each side over the GCD; the table scan that
// follows when needed visits every entry with a gap phase and a compare
// phase and then hands the best entry back.
// snap_limit is written on the cfg beat; the user must write it only while
// the block is idle, which the block itself does not enforce. It resets to
// 64; cfg_ready is always high.
module aspect_ratio_reducer
	import arr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [SIDE_BITS-1:0] cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire arr_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output arr_out_t                  out_data
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_EUC       = 4'd1;
	localparam logic [3:0] ST_EUC_WAIT  = 4'd2;
	localparam logic [3:0] ST_DIVW      = 4'd3;
	localparam logic [3:0] ST_DIVW_WAIT = 4'd4;
	localparam logic [3:0] ST_DIVH      = 4'd5;
	localparam logic [3:0] ST_DIVH_WAIT = 4'd6;
	localparam logic [3:0] ST_CHECK     = 4'd7;
	localparam logic [3:0] ST_SCAN_WAIT = 4'd8;
	localparam logic [3:0] ST_DONE      = 4'd9;

	logic [3:0]           state_q;
	logic [SIDE_BITS-1:0] snap_q;
	logic [SIDE_BITS-1:0] w_q;
	logic [SIDE_BITS-1:0] h_q;
	logic [SIDE_BITS-1:0] x_q;
	logic [SIDE_BITS-1:0] y_q;
	logic [SIDE_BITS-1:0] rw_q;
	logic [SIDE_BITS-1:0] rh_q;
	logic                 snapped_q;
	logic                 out_valid_q;
	arr_out_t             out_data_q;

	logic                 in_beat;
	logic [SIDE_BITS-1:0] w_fix;
	logic [SIDE_BITS-1:0] h_fix;
	logic                 div_start;
	logic [SIDE_BITS-1:0] div_n;
	logic [SIDE_BITS-1:0] div_d;
	div_rsp_t             div_rsp;
	logic                 scan_start;
	scan_rsp_t            scan_rsp;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// A zero side counts as one.
	assign w_fix = (in_data.width == '0) ? SIDE_BITS'(1) : in_data.width;
	assign h_fix = (in_data.height == '0) ? SIDE_BITS'(1) : in_data.height;

	// Divider operands: a remainder step of Euclid, then each side over the GCD.
	always_comb begin
		div_start = 1'b0;
		div_n     = x_q;
		div_d     = y_q;
		unique case (state_q)
			ST_EUC: begin
				div_start = (y_q != '0);
			end
			ST_DIVW: begin
				div_start = 1'b1;
				div_n     = w_q;
				div_d     = x_q;
			end
			ST_DIVH: begin
				div_start = 1'b1;
				div_n     = h_q;
				div_d     = x_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign scan_start = (state_q == ST_CHECK) && ((rw_q > snap_q) || (rh_q > snap_q));

	arr_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.rsp      (div_rsp)
	);

	arr_snap_scan u_snap_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.width  (w_q),
		.height (h_q),
		.rsp    (scan_rsp)
	);

	// Snap limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= SNAP_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			snap_q <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) state_q <= ST_EUC;
				end
				ST_EUC: begin
					state_q <= (y_q == '0) ? ST_DIVW : ST_EUC_WAIT;
				end
				ST_EUC_WAIT: begin
					if (div_rsp.done) state_q <= ST_EUC;
				end
				ST_DIVW: begin
					state_q <= ST_DIVW_WAIT;
				end
				ST_DIVW_WAIT: begin
					if (div_rsp.done) state_q <= ST_DIVH;
				end
				ST_DIVH: begin
					state_q <= ST_DIVH_WAIT;
				end
				ST_DIVH_WAIT: begin
					if (div_rsp.done) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= scan_start ? ST_SCAN_WAIT : ST_DONE;
				end
				ST_SCAN_WAIT: begin
					if (scan_rsp.done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			w_q <= w_fix;
			h_q <= h_fix;
			x_q <= w_fix;
			y_q <= h_fix;
		end
		if (state_q == ST_EUC_WAIT && div_rsp.done) begin
			x_q <= y_q;
			y_q <= div_rsp.rem;
		end
		if (state_q == ST_DIVW_WAIT && div_rsp.done) begin
			rw_q <= div_rsp.quot;
		end
		if (state_q == ST_DIVH_WAIT && div_rsp.done) begin
			rh_q <= div_rsp.quot;
		end
		if (state_q == ST_CHECK) begin
			snapped_q <= 1'b0;
		end
		if (state_q == ST_SCAN_WAIT && scan_rsp.done) begin
			rw_q      <= SIDE_BITS'(RATIO_NUM[scan_rsp.best]);
			rh_q      <= SIDE_BITS'(RATIO_DEN[scan_rsp.best]);
			snapped_q <= 1'b1;
		end
	end

	// Output register: holds the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q.ratio_num <= rw_q;
			out_data_q.ratio_den <= rh_q;
			out_data_q.snapped   <= snapped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An accepted beat keeps the block busy for at least the next cycle.
	`ARR_ASSERT_NEXT(a_busy_after_accept, in_beat, !in_ready)
	// The shared divider and the table scan are free whenever a new item can be taken.
	`ARR_ASSERT_NOW(a_div_free_when_idle, in_ready, !div_rsp.busy && !scan_rsp.busy)
	// A division finishes only while the sequencer waits for it.
	`ARR_ASSERT_NOW(a_div_done_expected, div_rsp.done,
		state_q == ST_EUC_WAIT || state_q == ST_DIVW_WAIT || state_q == ST_DIVH_WAIT)

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench of the aspect ratio reducer with a built-in ratio predictor.
`timescale 1ns / 1ps

module tb;
	import arr_pkg::*;

	// Common ratio table, in scan order.
	localparam int COMMON_COUNT = 11;
	localparam int unsigned COMMON_W [COMMON_COUNT] = '{16, 9, 4, 3, 3, 2, 1, 21, 5, 16, 10};
	localparam int unsigned COMMON_H [COMMON_COUNT] = '{9, 16, 3, 4, 2, 3, 1, 9, 4, 10, 16};

	// Wait after the last beat: twice the time of the worst item.
	localparam int DRAIN_CYCLES = 1000;
	localparam int MAX_SHOWN    = 10;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [SIDE_BITS-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	arr_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	arr_out_t             out_data;

	// Predictor state and scoreboard.
	logic [SIDE_BITS-1:0] limit_now = SNAP_LIMIT_RESET;
	arr_out_t             ratio_q[$];
	int                   mismatches = 0;
	bit                   steady     = 1'b0;
	int                   hold_left  = 0;

	aspect_ratio_reducer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicts the ratio for one canvas under the given snap limit.
	function automatic arr_out_t reduce_ratio(input arr_in_t item,
		input logic [SIDE_BITS-1:0] limit);
		longint unsigned w, h, x, y, r, rw, rh, gap, best_gap;
		int best;
		int i;
		arr_out_t res;
		w = item.width;
		h = item.height;
		if (w == 0)
			w = 1;
		if (h == 0)
			h = 1;
		// Euclid's GCD; both sides are at least one, so x ends nonzero.
		x = w;
		y = h;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		rw = w / x;
		rh = h / x;
		res.snapped = 1'b0;
		// Snap to the nearest common ratio, keeping the earlier entry on a tie.
		if (rw > limit || rh > limit) begin
			best = 0;
			best_gap = 0;
			for (i = 0; i < COMMON_COUNT; i++) begin
				if (COMMON_W[i] * h >= COMMON_H[i] * w)
					gap = COMMON_W[i] * h - COMMON_H[i] * w;
				else
					gap = COMMON_H[i] * w - COMMON_W[i] * h;
				if (i == 0 || gap * COMMON_H[best] < best_gap * COMMON_H[i]) begin
					best = i;
					best_gap = gap;
				end
			end
			rw = COMMON_W[best];
			rh = COMMON_H[best];
			res.snapped = 1'b1;
		end
		res.ratio_num = rw[SIDE_BITS-1:0];
		res.ratio_den = rh[SIDE_BITS-1:0];
		return res;
	endfunction

	// Result checker and receiver pacing, including the long hold-off.
	always @(posedge clk) begin
		arr_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (ratio_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("tb: result beat with nothing expected: num=%0d den=%0d snapped=%0b",
						out_data.ratio_num, out_data.ratio_den, out_data.snapped);
			end else begin
				want = ratio_q.pop_front();
				if (out_data.ratio_num !== want.ratio_num || out_data.ratio_den !== want.ratio_den
					|| out_data.snapped !== want.snapped) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("tb: mismatch: expected %0d:%0d snapped=%0b, got %0d:%0d snapped=%0b",
							want.ratio_num, want.ratio_den, want.snapped,
							out_data.ratio_num, out_data.ratio_den, out_data.snapped);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 26);
		end
	end

	// Offers one canvas beat and records its expected ratio once accepted.
	task automatic send_item(input logic [SIDE_BITS-1:0] w, input logic [SIDE_BITS-1:0] h);
		arr_in_t item;
		item.width = w;
		item.height = h;
		while (!steady && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ratio_q.push_back(reduce_ratio(item, limit_now));
	endtask

	// Drains all results, then writes the snap limit on the cfg beat.
	task automatic write_snap(input logic [SIDE_BITS-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (ratio_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		limit_now = value;
	endtask

	// Side extremes, zero sides and reduction edges at the reset limit.
	task automatic test_reset_limit();
		send_item(16'd0, 16'd0);
		send_item(16'd0, 16'd65535);
		send_item(16'd65535, 16'd0);
		send_item(16'd65535, 16'd65535);
		send_item(16'd1920, 16'd1080);
		send_item(16'd1080, 16'd1920);
		send_item(16'd64, 16'd1);
		send_item(16'd65, 16'd1);
		send_item(16'd1, 16'd64);
		send_item(16'd1366, 16'd768);
		send_item(16'd65535, 16'd65534);
		send_item(16'd65521, 16'd1);
		send_item(16'hAAAA, 16'h5555);
		send_item(16'd46368, 16'd28657);
	endtask

	// Limit zero snaps everything, limit one keeps only 1:1, the top limit never snaps.
	task automatic test_limit_extremes();
		write_snap(16'd0);
		// 17:12 lies exactly midway between 4:3 and 3:2.
		send_item(16'd17, 16'd12);
		send_item(16'd1, 16'd1);
		send_item(16'd100, 16'd100);
		send_item(16'd5, 16'd3);
		write_snap(16'd1);
		send_item(16'd2, 16'd1);
		send_item(16'd3, 16'd3);
		send_item(16'd1, 16'd2);
		write_snap(16'd65535);
		send_item(16'd65535, 16'd1);
		send_item(16'd65534, 16'd65535);
		send_item(16'd1, 16'd65535);
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		int n;
		write_snap(SNAP_LIMIT_RESET);
		hold_left = 300;
		for (n = 0; n < 12; n++)
			send_item(SIDE_BITS'($urandom), SIDE_BITS'($urandom));
	endtask

	// Random canvases over several limits, biased toward common ratios and deep GCDs.
	task automatic test_random();
		logic [SIDE_BITS-1:0] phase_limit [8];
		int phase, n, pick, idx, steps, j;
		int unsigned k, a, b, t;
		logic [SIDE_BITS-1:0] w, h;
		phase_limit[0] = SNAP_LIMIT_RESET;
		phase_limit[1] = 16'd1;
		phase_limit[2] = 16'd65535;
		phase_limit[3] = SIDE_BITS'($urandom_range(255, 2));
		phase_limit[4] = SIDE_BITS'($urandom);
		phase_limit[5] = 16'd0;
		phase_limit[6] = SIDE_BITS'($urandom_range(64, 1));
		phase_limit[7] = SNAP_LIMIT_RESET;
		for (phase = 0; phase < 8; phase++) begin
			write_snap(phase_limit[phase]);
			// One whole phase runs with no idling on either side.
			steady = (phase == 2);
			for (n = 0; n < 138; n++) begin
				pick = $urandom_range(99);
				if (pick < 25) begin
					w = SIDE_BITS'($urandom);
					h = SIDE_BITS'($urandom);
				end else if (pick < 55) begin
					// Scaled table ratio with a little jitter.
					idx = $urandom_range(COMMON_COUNT - 1);
					k = $urandom_range(3120, 1);
					w = SIDE_BITS'(COMMON_W[idx] * k + $urandom_range(3));
					h = SIDE_BITS'(COMMON_H[idx] * k + $urandom_range(1));
				end else if (pick < 70) begin
					w = SIDE_BITS'($urandom_range(300));
					h = SIDE_BITS'($urandom_range(300));
				end else if (pick < 78) begin
					if ($urandom_range(1)) begin
						w = 16'd0;
						h = SIDE_BITS'($urandom);
					end else begin
						w = SIDE_BITS'($urandom);
						h = 16'd0;
					end
				end else if (pick < 90) begin
					w = SIDE_BITS'($urandom);
					h = w + ($urandom_range(1) ? 16'd1 : 16'hFFFF);
				end else begin
					// Consecutive Fibonacci numbers make Euclid run longest.
					steps = $urandom_range(23, 2);
					a = 1;
					b = 1;
					for (j = 0; j < steps; j++) begin
						t = a + b;
						a = b;
						b = t;
					end
					if ($urandom_range(1)) begin
						w = SIDE_BITS'(b);
						h = SIDE_BITS'(a);
					end else begin
						w = SIDE_BITS'(a);
						h = SIDE_BITS'(b);
					end
				end
				send_item(w, h);
			end
		end
		steady = 1'b0;
	endtask

	// Main sequence: reset, tests in turn, drain, verdict.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_limit();
		test_limit_extremes();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ratio_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Run limit, several times the slowest passing run.
	initial begin
		#8000000;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/arr_pkg.sv
rtl/arr_divider.sv
rtl/arr_snap_scan.sv
rtl/aspect_ratio_reducer.sv
tb/sv/tb.sv
